>>> hdl/symmetric_5x5_stencil_filter_unit_macros.svh
// Assertion macros shared by the stencil filter RTL.
`ifndef SYMMETRIC_5X5_STENCIL_FILTER_UNIT_MACROS_SVH
`define SYMMETRIC_5X5_STENCIL_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define S5SF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define S5SF_ASSERT(label, prop, msg) \
  `S5SF_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define S5SF_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define S5SF_ASSERT(label, prop, msg)
`endif
`endif

>>> hdl/s5sf_pkg.sv
// Shared types and constants of the stencil filter.
`default_nettype none
package s5sf_pkg;

  localparam int WeightBits  = 18;
  localparam int NumGroups   = 6;
  localparam int WidthBits   = 11;
  localparam int HeightBits  = 16;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 18;
  localparam int FracBits    = 16;
  localparam int WinSize     = 5;
  localparam int MinDim      = 5;
  localparam int FifoDepth   = 16;
  localparam int FifoPtrBits = 4;
  localparam int FifoCntBits = 5;

  localparam logic [WidthBits-1:0]  FrameWidthReset  = 11'd1024;
  localparam logic [HeightBits-1:0] FrameHeightReset = 16'd1024;

  typedef logic signed [WeightBits-1:0] weight_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_WEIGHT_CENTRE    = 3'd0,
    CFG_WEIGHT_AXIS_NEAR = 3'd1,
    CFG_WEIGHT_AXIS_FAR  = 3'd2,
    CFG_WEIGHT_DIAG_NEAR = 3'd3,
    CFG_WEIGHT_DIAG_FAR  = 3'd4,
    CFG_WEIGHT_KNIGHT    = 3'd5,
    CFG_FRAME_WIDTH      = 3'd6,
    CFG_FRAME_HEIGHT     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic keep;
    logic frame_end;
  } ctrl_t;

endpackage
`default_nettype wire

>>> hdl/s5sf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module s5sf_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hdl/s5sf_window.sv
// Raster counters, line store read-modify-write and 5x5 window.
`default_nettype none
module s5sf_window #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  input  logic [s5sf_pkg::WidthBits-1:0]    frame_width_i,
  input  logic [s5sf_pkg::HeightBits-1:0]   frame_height_i,
  output logic                              produce_o,
  output logic [SAMPLE_BITS-1:0]            win_o [s5sf_pkg::WinSize][s5sf_pkg::WinSize],
  output s5sf_pkg::ctrl_t                   ctrl_o
);
  import s5sf_pkg::*;

  `include "symmetric_5x5_stencil_filter_unit_macros.svh"

  localparam int ColBits   = $clog2(MAX_WIDTH);
  localparam int CmpBits   = (ColBits + 1 > WidthBits) ? ColBits + 1 : WidthBits;
  localparam int LineBits  = (WinSize - 1) * SAMPLE_BITS;
  localparam int LastLane  = WinSize - 1;
  localparam int FirstKeep = WinSize - 1;

  logic [ColBits-1:0]     col_q, col_d, col1_q;
  logic [HeightBits-1:0]  row_q, row_d;
  logic [SAMPLE_BITS-1:0] sample1_q;
  logic                   v1_q;
  ctrl_t                  ctrl1_q, ctrl2_q, ctrl_cur;
  logic [CmpBits-1:0]     w_raw, w_max, w_eff, col_next;
  logic [HeightBits-1:0]  h_eff;
  logic                   last_col, last_row;
  logic [LineBits-1:0]    line_rdata, line_wdata;
  logic [SAMPLE_BITS-1:0] col_data [WinSize];
  logic [SAMPLE_BITS-1:0] win_q [WinSize][WinSize];

  always_comb begin
    w_raw    = CmpBits'(frame_width_i);
    w_max    = CmpBits'(MAX_WIDTH);
    w_eff    = (w_raw < CmpBits'(MinDim)) ? CmpBits'(MinDim) :
               (w_raw > w_max) ? w_max : w_raw;
    h_eff    = (frame_height_i < HeightBits'(MinDim)) ? HeightBits'(MinDim) : frame_height_i;
    col_next = CmpBits'(col_q) + CmpBits'(1);
    last_col = col_next >= w_eff;
    last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
    produce_o = (col_q >= ColBits'(FirstKeep)) && (row_q >= HeightBits'(FirstKeep));
    ctrl_cur.keep      = produce_o;
    ctrl_cur.frame_end = last_row && last_col;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + HeightBits'(1);
    end else begin
      col_d = col_next[ColBits-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      v1_q    <= 1'b0;
      ctrl1_q <= '0;
      ctrl2_q <= '0;
    end else begin
      v1_q    <= accept_i;
      ctrl1_q <= accept_i ? ctrl_cur : '0;
      ctrl2_q <= ctrl1_q;
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      col1_q    <= col_q;
      sample1_q <= sample_i;
    end
  end

  s5sf_ram #(
    .Width (LineBits),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (col1_q),
    .wdata_i (line_wdata),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  always_comb begin
    for (int k = 0; k < LastLane; k++) begin
      col_data[k] = line_rdata[k*SAMPLE_BITS +: SAMPLE_BITS];
    end
    col_data[LastLane] = sample1_q;
  end

  assign line_wdata = {sample1_q, line_rdata[LineBits-1:SAMPLE_BITS]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinSize; k++) begin
        for (int j = 0; j < WinSize; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else if (v1_q) begin
      for (int k = 0; k < WinSize; k++) begin
        for (int j = 0; j < LastLane; j++) begin
          win_q[k][j] <= win_q[k][j+1];
        end
        win_q[k][LastLane] <= col_data[k];
      end
    end
  end

  assign win_o  = win_q;
  assign ctrl_o = ctrl2_q;

  `S5SF_ASSERT(a_line_rmw_distinct, (v1_q && accept_i) |-> (col_q != col1_q), "line store read hits pending write")
  `S5SF_ASSERT(a_col_in_range, CmpBits'(col_q) < w_max, "column count beyond line store")
  `S5SF_ASSERT(a_keep_needs_item, ctrl1_q.keep |-> v1_q, "keep flag without item")

endmodule
`default_nettype wire

>>> hdl/s5sf_mac.sv
// Group sums, weight multiply, accumulate, round and saturate pipeline.
`default_nettype none
module s5sf_mac #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [SAMPLE_BITS-1:0] win_i [s5sf_pkg::WinSize][s5sf_pkg::WinSize],
  input  s5sf_pkg::ctrl_t        ctrl_i,
  input  s5sf_pkg::weight_t      weights_i [s5sf_pkg::NumGroups],
  output s5sf_pkg::ctrl_t        ctrl_o,
  output logic [SAMPLE_BITS-1:0] filtered_o
);
  import s5sf_pkg::*;

  localparam int GBits = SAMPLE_BITS + 3;
  localparam int PBits = GBits + WeightBits;
  localparam int QBits = PBits + 1;
  localparam int ABits = PBits + 3;
  localparam int RBits = ABits - FracBits;
  localparam int NumPairs = NumGroups / 2;
  localparam logic signed [ABits-1:0] RoundBias = ABits'(64'sd1 <<< (FracBits - 1));

  function automatic logic signed [GBits-1:0] sx(input logic [SAMPLE_BITS-1:0] x);
    return GBits'($signed(x));
  endfunction

  logic signed [GBits-1:0] grp_d [NumGroups];
  logic signed [GBits-1:0] grp_q [NumGroups];
  logic signed [PBits-1:0] prod_q [NumGroups];
  logic signed [QBits-1:0] pair_q [NumPairs];
  logic signed [ABits-1:0] acc_q;
  logic signed [RBits-1:0] quo;
  logic [SAMPLE_BITS-1:0]  res_d, res_q;
  logic                    sat_hi, sat_lo;
  ctrl_t                   ctrl_g_q, ctrl_p_q, ctrl_r_q, ctrl_a_q, ctrl_o_q;

  always_comb begin
    grp_d[0] = sx(win_i[2][2]);
    grp_d[1] = sx(win_i[1][2]) + sx(win_i[3][2]) + sx(win_i[2][1]) + sx(win_i[2][3]);
    grp_d[2] = sx(win_i[0][2]) + sx(win_i[4][2]) + sx(win_i[2][0]) + sx(win_i[2][4]);
    grp_d[3] = sx(win_i[1][1]) + sx(win_i[1][3]) + sx(win_i[3][1]) + sx(win_i[3][3]);
    grp_d[4] = sx(win_i[0][0]) + sx(win_i[0][4]) + sx(win_i[4][0]) + sx(win_i[4][4]);
    grp_d[5] = (sx(win_i[0][1]) + sx(win_i[0][3]) + sx(win_i[4][1]) + sx(win_i[4][3]))
             + (sx(win_i[1][0]) + sx(win_i[3][0]) + sx(win_i[1][4]) + sx(win_i[3][4]));
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumGroups; i++) begin
      grp_q[i]  <= grp_d[i];
      prod_q[i] <= PBits'(grp_q[i]) * PBits'(weights_i[i]);
    end
    for (int i = 0; i < NumPairs; i++) begin
      pair_q[i] <= QBits'(prod_q[2*i]) + QBits'(prod_q[2*i+1]);
    end
    acc_q <= ABits'(pair_q[0]) + ABits'(pair_q[1]) + ABits'(pair_q[2]) + RoundBias;
    res_q <= res_d;
  end

  always_comb begin
    quo    = acc_q[ABits-1:FracBits];
    sat_hi = !quo[RBits-1] && (|quo[RBits-2:SAMPLE_BITS-1]);
    sat_lo = quo[RBits-1] && !(&quo[RBits-2:SAMPLE_BITS-1]);
    if (sat_hi) begin
      res_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (sat_lo) begin
      res_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res_d = quo[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_g_q <= '0;
      ctrl_p_q <= '0;
      ctrl_r_q <= '0;
      ctrl_a_q <= '0;
      ctrl_o_q <= '0;
    end else begin
      ctrl_g_q <= ctrl_i;
      ctrl_p_q <= ctrl_g_q;
      ctrl_r_q <= ctrl_p_q;
      ctrl_a_q <= ctrl_r_q;
      ctrl_o_q <= ctrl_a_q;
    end
  end

  assign ctrl_o     = ctrl_o_q;
  assign filtered_o = res_q;

endmodule
`default_nettype wire

>>> hdl/symmetric_5x5_stencil_filter_unit.sv
// Top level of the symmetric 5x5 stencil filter unit.
`default_nettype none
// Takes one sample per clock while ready, in raster order, halo included, and
// returns one filtered Q16.16 value for every interior centre, with frame_end
// set on the last one of a frame. Throughput is one sample per cycle while
// ready: each transfer does one read and one write of the column-wide line
// RAM (four rows per word), and those accesses never touch the same column
// in consecutive cycles. A result passes the window and MAC registers into a
// 16-entry output queue that absorbs back-pressure; input ready drops once
// 16 results are pending. Write the configuration only while the block is idle.
module symmetric_5x5_stencil_filter_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [s5sf_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [s5sf_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [SAMPLE_BITS-1:0]            filtered_o,
  output logic                              frame_end_o
);
  import s5sf_pkg::*;

  `include "symmetric_5x5_stencil_filter_unit_macros.svh"

  weight_t                weight_q [NumGroups];
  weight_t                weight_d [NumGroups];
  logic [WidthBits-1:0]   frame_width_q, frame_width_d;
  logic [HeightBits-1:0]  frame_height_q, frame_height_d;

  logic                   accept, pop, produce;
  logic [SAMPLE_BITS-1:0] win [WinSize][WinSize];
  ctrl_t                  win_ctrl, mac_ctrl;
  logic [SAMPLE_BITS-1:0] mac_res;

  logic [SAMPLE_BITS-1:0] fifo_res_q [FifoDepth];
  logic                   fifo_fe_q [FifoDepth];
  logic [FifoPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntBits-1:0] fifo_cnt_q, fifo_cnt_d;
  logic [FifoCntBits-1:0] pending_q, pending_d;
  logic                   push, pend_inc;

  always_comb begin
    weight_d       = weight_q;
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WEIGHT_CENTRE:    weight_d[0] = cfg_data_i[WeightBits-1:0];
        CFG_WEIGHT_AXIS_NEAR: weight_d[1] = cfg_data_i[WeightBits-1:0];
        CFG_WEIGHT_AXIS_FAR:  weight_d[2] = cfg_data_i[WeightBits-1:0];
        CFG_WEIGHT_DIAG_NEAR: weight_d[3] = cfg_data_i[WeightBits-1:0];
        CFG_WEIGHT_DIAG_FAR:  weight_d[4] = cfg_data_i[WeightBits-1:0];
        CFG_WEIGHT_KNIGHT:    weight_d[5] = cfg_data_i[WeightBits-1:0];
        CFG_FRAME_WIDTH:      frame_width_d = cfg_data_i[WidthBits-1:0];
        CFG_FRAME_HEIGHT:     frame_height_d = cfg_data_i[HeightBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumGroups; i++) begin
        weight_q[i] <= '0;
      end
      frame_width_q  <= FrameWidthReset;
      frame_height_q <= FrameHeightReset;
    end else begin
      weight_q       <= weight_d;
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  assign in_ready_o = pending_q < FifoCntBits'(FifoDepth);
  assign accept     = in_valid_i && in_ready_o;

  s5sf_window #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .sample_i       (sample_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .produce_o      (produce),
    .win_o          (win),
    .ctrl_o         (win_ctrl)
  );

  s5sf_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .win_i      (win),
    .ctrl_i     (win_ctrl),
    .weights_i  (weight_q),
    .ctrl_o     (mac_ctrl),
    .filtered_o (mac_res)
  );

  assign push        = mac_ctrl.keep;
  assign out_valid_o = fifo_cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign pend_inc    = accept && produce;
  assign filtered_o  = fifo_res_q[rd_ptr_q];
  assign frame_end_o = fifo_fe_q[rd_ptr_q];

  always_comb begin
    fifo_cnt_d = fifo_cnt_q;
    if (push && !pop) begin
      fifo_cnt_d = fifo_cnt_q + FifoCntBits'(1);
    end else if (pop && !push) begin
      fifo_cnt_d = fifo_cnt_q - FifoCntBits'(1);
    end
    pending_d = pending_q;
    if (pend_inc && !pop) begin
      pending_d = pending_q + FifoCntBits'(1);
    end else if (pop && !pend_inc) begin
      pending_d = pending_q - FifoCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      pending_q  <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_d;
      pending_q  <= pending_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrBits'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_res_q[wr_ptr_q] <= mac_res;
      fifo_fe_q[wr_ptr_q]  <= mac_ctrl.frame_end;
    end
  end

  `S5SF_ASSERT(a_fifo_within_pending, fifo_cnt_q <= pending_q, "queue holds more than pending")
  `S5SF_ASSERT(a_fifo_no_overflow, !(push && !pop && (fifo_cnt_q == FifoCntBits'(FifoDepth))), "output queue overflow")
  `S5SF_ASSERT(a_pending_bound, pending_q <= FifoCntBits'(FifoDepth), "pending count beyond queue depth")

endmodule
`default_nettype wire
